FILE: hw/rtl/cscr_pkg.sv
// Package for the console serial and line clock register block.
// Holds the item types, function codes, I/O page addresses and register bits.
// No dependencies.
package cscr_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic        byte_access;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [7:0]  key_code;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        bus_error;
    logic        char_valid;
    logic [6:0]  char_code;
    logic [1:0]  irq_source;
    logic        end_key_seen;
  } rsp_t;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_KEY   = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [1:0] IRQ_NONE = 2'd0;
  localparam logic [1:0] IRQ_RX   = 2'd1;
  localparam logic [1:0] IRQ_TX   = 2'd2;
  localparam logic [1:0] IRQ_CLK  = 2'd3;

  localparam logic [15:0] ADDR_RCSR = 16'o177560;
  localparam logic [15:0] ADDR_RBUF = 16'o177562;
  localparam logic [15:0] ADDR_TCSR = 16'o177564;
  localparam logic [15:0] ADDR_TBUF = 16'o177566;
  localparam logic [15:0] ADDR_SWR  = 16'o177570;
  localparam logic [15:0] ADDR_LKS  = 16'o177546;
  localparam logic [15:0] ADDR_PSB  = 16'o177776;

  localparam int BIT_DONE = 7;
  localparam int BIT_IE   = 6;

  localparam logic [7:0] KEY_END   = 8'd4;
  localparam logic [7:0] KEY_CTRL  = 8'd1;
  localparam logic [7:0] KEY_BREAK = 8'd3;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_DEL   = 8'd127;

  localparam logic CFG_IRQ_DELAY    = 1'b0;
  localparam logic CFG_CLOCK_PERIOD = 1'b1;

  localparam logic [5:0]  IRQ_DELAY_RESET    = 6'd50;
  localparam logic [13:0] CLOCK_PERIOD_RESET = 14'd10000;

endpackage

FILE: hw/rtl/console_serial_and_clock_regs.sv
// Console receiver/transmitter, line clock, switch and status byte registers.
// Unstalled, one item per cycle: bus read, bus write, key arrival or tick.
// Depends on cscr_pkg.

// Register state is updated and the result formed in the same cycle the item
// is accepted; the result sits in an output register from the next cycle. A
// new item is accepted every cycle unless rsp_stall holds a finished result.
// Configuration (irq_delay at byte address 0, clock_period at byte address 4)
// is written over the APB port; the user must do so only while no item is in
// flight; the block does not enforce this. Address bit 2 alone selects it.
module console_serial_and_clock_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  cscr_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output cscr_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cscr_pkg::*;

  logic [5:0]  irq_delay;
  logic [13:0] clock_period;

  logic        rx_done, rx_ie, tx_done, tx_ie, tx_pending;
  logic [7:0]  rx_buffer, tx_buffer, status_byte;
  logic [5:0]  rx_cnt, tx_cnt;
  logic [13:0] clk_cnt;
  logic        clk_mon, clk_ie, clk_irq;
  logic [15:0] switch_value;
  logic        end_key;

  logic        rx_done_next, rx_ie_next, tx_done_next, tx_ie_next, tx_pending_next;
  logic [7:0]  rx_buffer_next, tx_buffer_next, status_byte_next;
  logic [5:0]  rx_cnt_next, tx_cnt_next;
  logic [13:0] clk_cnt_next;
  logic        clk_mon_next, clk_ie_next, clk_irq_next;
  logic [15:0] switch_value_next;
  logic        end_key_next;
  rsp_t        rsp_next;

  logic        acc;
  logic [15:0] wdata;
  logic [15:0] rd;
  logic [5:0]  tx_cnt_v, rx_dec, tx_dec;
  logic        clk_irq_v;
  logic [7:0]  key_v;

  assign acc       = req_valid && !req_stall;
  assign req_stall = rsp_valid && rsp_stall;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == CFG_CLOCK_PERIOD) ? {18'd0, clock_period}
                                                    : {26'd0, irq_delay};
  assign wdata     = req.byte_access ? {8'd0, req.write_data[7:0]} : req.write_data;

  always_comb begin
    rx_done_next      = rx_done;
    rx_ie_next        = rx_ie;
    rx_buffer_next    = rx_buffer;
    rx_cnt_next       = rx_cnt;
    tx_done_next      = tx_done;
    tx_ie_next        = tx_ie;
    tx_buffer_next    = tx_buffer;
    tx_pending_next   = tx_pending;
    tx_cnt_next       = tx_cnt;
    clk_cnt_next      = clk_cnt;
    clk_mon_next      = clk_mon;
    clk_ie_next       = clk_ie;
    clk_irq_next      = clk_irq;
    status_byte_next  = status_byte;
    switch_value_next = switch_value;
    end_key_next      = end_key;
    rsp_next          = '0;
    rd                = 16'd0;
    tx_cnt_v          = tx_cnt;
    rx_dec            = rx_cnt;
    tx_dec            = tx_cnt;
    clk_irq_v         = clk_irq;
    key_v             = req.key_code;

    case (req.func)
      FUNC_READ: begin
        case (req.address)
          ADDR_RCSR: rd = {8'd0, rx_done, rx_ie, 6'd0};
          ADDR_RBUF: begin
            rd = {8'd0, rx_buffer};
            rx_done_next = 1'b0;
          end
          ADDR_TCSR: rd = {8'd0, tx_done, tx_ie, 6'd0};
          ADDR_SWR:  rd = switch_value;
          ADDR_LKS:  rd = {8'd0, clk_mon, clk_ie, 6'd0};
          ADDR_PSB:  rd = {8'd0, status_byte};
          default:   rsp_next.bus_error = 1'b1;
        endcase
        rsp_next.read_data = req.byte_access ? {8'd0, rd[7:0]} : rd;
      end
      FUNC_WRITE: begin
        case (req.address)
          ADDR_RCSR: rx_ie_next = wdata[BIT_IE];
          ADDR_TCSR: begin
            tx_ie_next = wdata[BIT_IE];
            if (wdata[BIT_IE]) begin
              tx_cnt_next = irq_delay;
            end
          end
          ADDR_TBUF: begin
            tx_pending_next = 1'b1;
            tx_buffer_next  = wdata[7:0];
            tx_done_next    = 1'b0;
          end
          ADDR_LKS: begin
            clk_mon_next = wdata[BIT_DONE];
            clk_ie_next  = wdata[BIT_IE];
          end
          ADDR_PSB: status_byte_next  = wdata[7:0];
          ADDR_SWR: switch_value_next = wdata;
          default:  rsp_next.bus_error = 1'b1;
        endcase
      end
      FUNC_KEY: begin
        if (req.key_code == KEY_END) begin
          end_key_next = 1'b1;
        end else begin
          if (req.key_code == KEY_CTRL) begin
            key_v = KEY_BREAK;
          end else if (req.key_code == KEY_BS) begin
            key_v = KEY_DEL;
          end
          rx_buffer_next = key_v;
          rx_done_next   = 1'b1;
          if (rx_ie) begin
            rx_cnt_next = irq_delay;
          end
        end
      end
      FUNC_TICK: begin
        if (tx_pending) begin
          tx_pending_next     = 1'b0;
          rsp_next.char_valid = |tx_buffer;
          rsp_next.char_code  = (|tx_buffer) ? tx_buffer[6:0] : 7'd0;
          if (tx_ie) begin
            tx_cnt_v = irq_delay;
          end
        end
        tx_done_next = 1'b1;

        if (clk_cnt > clock_period || clk_cnt == '1) begin
          clk_mon_next = 1'b1;
          if (clk_ie) begin
            clk_irq_v = 1'b1;
          end
          clk_cnt_next = '0;
        end else begin
          clk_cnt_next = clk_cnt + 14'd1;
        end

        rx_dec = (rx_cnt > 6'd1) ? rx_cnt - 6'd1 : rx_cnt;
        tx_dec = (tx_cnt_v > 6'd1) ? tx_cnt_v - 6'd1 : tx_cnt_v;
        if (rx_dec == 6'd1) begin
          rx_cnt_next         = '0;
          tx_cnt_next         = tx_cnt_v;
          rsp_next.irq_source = IRQ_RX;
        end else begin
          rx_cnt_next = rx_dec;
          if (tx_dec == 6'd1) begin
            tx_cnt_next         = '0;
            rsp_next.irq_source = IRQ_TX;
          end else begin
            tx_cnt_next = tx_dec;
            if (clk_irq_v) begin
              clk_irq_v           = 1'b0;
              rsp_next.irq_source = IRQ_CLK;
            end
          end
        end
        clk_irq_next = clk_irq_v;
      end
      default: ;
    endcase
    rsp_next.end_key_seen = end_key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_delay    <= IRQ_DELAY_RESET;
      clock_period <= CLOCK_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == CFG_CLOCK_PERIOD) begin
        clock_period <= pwdata[13:0];
      end else begin
        irq_delay <= pwdata[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_done      <= 1'b0;
      rx_ie        <= 1'b0;
      rx_buffer    <= '0;
      rx_cnt       <= '0;
      tx_done      <= 1'b0;
      tx_ie        <= 1'b0;
      tx_buffer    <= '0;
      tx_pending   <= 1'b0;
      tx_cnt       <= '0;
      clk_cnt      <= '0;
      clk_mon      <= 1'b1;
      clk_ie       <= 1'b0;
      clk_irq      <= 1'b0;
      status_byte  <= '0;
      switch_value <= '0;
      end_key      <= 1'b0;
    end else if (acc) begin
      rx_done      <= rx_done_next;
      rx_ie        <= rx_ie_next;
      rx_buffer    <= rx_buffer_next;
      rx_cnt       <= rx_cnt_next;
      tx_done      <= tx_done_next;
      tx_ie        <= tx_ie_next;
      tx_buffer    <= tx_buffer_next;
      tx_pending   <= tx_pending_next;
      tx_cnt       <= tx_cnt_next;
      clk_cnt      <= clk_cnt_next;
      clk_mon      <= clk_mon_next;
      clk_ie       <= clk_ie_next;
      clk_irq      <= clk_irq_next;
      status_byte  <= status_byte_next;
      switch_value <= switch_value_next;
      end_key      <= end_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp <= rsp_next;
    end
  end

  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    acc && req.func != FUNC_TICK |=> rsp.irq_source == IRQ_NONE && !rsp.char_valid)
    else $error("interrupt or character on a non-tick item");

  a_tick_sets_tx_done: assert property (@(posedge clk) disable iff (rst)
    acc && req.func == FUNC_TICK |=> tx_done && !tx_pending)
    else $error("tick left transmitter busy");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bus_error |-> rsp.read_data == 16'd0 && !rsp.char_valid)
    else $error("bus error item carries data");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("input stalled with no result held");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for console_serial_and_clock_regs.
// Drives random and directed items, predicts every result and checks it.
// Depends on cscr_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cscr_pkg::*;

  localparam logic [7:0] LC_MASK = 8'hC0;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  console_serial_and_clock_regs u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted register file
  logic [5:0]  cfg_delay = IRQ_DELAY_RESET;
  logic [13:0] cfg_period = CLOCK_PERIOD_RESET;
  logic [7:0]  rcv_csr = '0;
  logic [7:0]  rcv_buf = '0;
  logic [7:0]  xmt_csr = '0;
  logic [7:0]  xmt_buf = '0;
  logic        xmt_full = 1'b0;
  logic [5:0]  rcv_wait = '0;
  logic [5:0]  xmt_wait = '0;
  logic [13:0] lc_count = '0;
  logic [7:0]  lc_csr = 8'h80;
  logic        lc_irq = 1'b0;
  logic [7:0]  psw_byte = '0;
  logic [15:0] swr = '0;
  logic        end_seen = 1'b0;

  req_t pending_items[$];
  rsp_t expected_rsp[$];
  req_t taken;
  rsp_t want;
  int   in_flight = 0;
  int   errors = 0;
  int   idle_pct = 0;
  int   long_hold = 0;
  int   src_gap = 0;
  int   sink_gap = 0;
  int   quiet_cycles = 0;
  logic req_fire = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rsp_t console_next(input req_t r);
    rsp_t        o;
    logic [15:0] d;
    logic [7:0]  k;
    o = '0;
    case (r.func)
      FUNC_READ: begin
        case (r.address)
          ADDR_RCSR: o.read_data = {8'h00, rcv_csr};
          ADDR_RBUF: begin
            rcv_csr[BIT_DONE] = 1'b0;
            o.read_data = {8'h00, rcv_buf};
          end
          ADDR_TCSR: o.read_data = {8'h00, xmt_csr};
          ADDR_SWR:  o.read_data = swr;
          ADDR_LKS:  o.read_data = {8'h00, lc_csr & LC_MASK};
          ADDR_PSB:  o.read_data = {8'h00, psw_byte};
          default:   o.bus_error = 1'b1;
        endcase
        if (r.byte_access) o.read_data[15:8] = 8'h00;
      end
      FUNC_WRITE: begin
        d = r.byte_access ? {8'h00, r.write_data[7:0]} : r.write_data;
        case (r.address)
          ADDR_RCSR: rcv_csr[BIT_IE] = d[BIT_IE];
          ADDR_TCSR: begin
            xmt_csr[BIT_IE] = d[BIT_IE];
            if (d[BIT_IE]) xmt_wait = cfg_delay;
          end
          ADDR_TBUF: begin
            xmt_full = 1'b1;
            xmt_buf = d[7:0];
            xmt_csr[BIT_DONE] = 1'b0;
          end
          ADDR_LKS: lc_csr = d[7:0] & LC_MASK;
          ADDR_PSB: psw_byte = d[7:0];
          ADDR_SWR: swr = d;
          default:  o.bus_error = 1'b1;
        endcase
      end
      FUNC_KEY: begin
        if (r.key_code == KEY_END) begin
          end_seen = 1'b1;
        end else begin
          k = r.key_code;
          if (k == KEY_CTRL) k = KEY_BREAK;
          else if (k == KEY_BS) k = KEY_DEL;
          rcv_buf = k;
          rcv_csr[BIT_DONE] = 1'b1;
          if (rcv_csr[BIT_IE]) rcv_wait = cfg_delay;
        end
      end
      default: begin
        if (xmt_full) begin
          xmt_full = 1'b0;
          if (xmt_buf != 8'h00) begin
            o.char_valid = 1'b1;
            o.char_code = xmt_buf[6:0];
          end
          if (xmt_csr[BIT_IE]) xmt_wait = cfg_delay;
        end
        xmt_csr[BIT_DONE] = 1'b1;
        if (lc_count > cfg_period || lc_count == 14'h3FFF) begin
          lc_csr[BIT_DONE] = 1'b1;
          if (lc_csr[BIT_IE]) lc_irq = 1'b1;
          lc_count = '0;
        end else begin
          lc_count = lc_count + 14'd1;
        end
        if (rcv_wait > 6'd1) rcv_wait = rcv_wait - 6'd1;
        if (rcv_wait == 6'd1) begin
          rcv_wait = '0;
          o.irq_source = IRQ_RX;
        end else begin
          if (xmt_wait > 6'd1) xmt_wait = xmt_wait - 6'd1;
          if (xmt_wait == 6'd1) begin
            xmt_wait = '0;
            o.irq_source = IRQ_TX;
          end else if (lc_irq) begin
            lc_irq = 1'b0;
            o.irq_source = IRQ_CLK;
          end
        end
      end
    endcase
    o.end_key_seen = end_seen;
    return o;
  endfunction

  function automatic req_t mk_item(input logic [1:0] f, input logic b, input logic [15:0] a,
                                   input logic [15:0] d, input logic [7:0] k);
    req_t r;
    r.func = f;
    r.byte_access = b;
    r.address = a;
    r.write_data = d;
    r.key_code = k;
    return r;
  endfunction

  function automatic req_t rand_item();
    req_t        r;
    logic [63:0] bits;
    int          sel;
    bits = {$urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    sel = $urandom_range(0, 99);
    if (sel < 25) r.func = FUNC_READ;
    else if (sel < 55) r.func = FUNC_WRITE;
    else if (sel < 67) r.func = FUNC_KEY;
    else r.func = FUNC_TICK;
    case ($urandom_range(0, 9))
      0: r.address = ADDR_RCSR;
      1: r.address = ADDR_RBUF;
      2: r.address = ADDR_TCSR;
      3: r.address = ADDR_TBUF;
      4: r.address = ADDR_SWR;
      5: r.address = ADDR_LKS;
      6: r.address = ADDR_PSB;
      7: r.address = ADDR_RCSR ^ (16'h0001 << $urandom_range(0, 15));
      default: ;
    endcase
    case ($urandom_range(0, 11))
      0: r.key_code = KEY_END;
      1: r.key_code = KEY_CTRL;
      2: r.key_code = KEY_BS;
      3: r.key_code = 8'h00;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] exp_v);
    if (errors < 40) $display("mismatch on %s: got %0h, want %0h", field, got, exp_v);
    errors++;
  endtask

  task automatic push(input req_t r);
    pending_items.push_back(r);
    in_flight++;
  endtask

  task automatic settle();
    while (in_flight != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == CFG_IRQ_DELAY) cfg_delay = v[5:0];
    else cfg_period = v[13:0];
  endtask

  task automatic run_random(input logic [5:0] dly, input logic [13:0] per, input int n,
                            input int idle, input int hold);
    settle();
    write_reg(CFG_IRQ_DELAY, {26'd0, dly});
    write_reg(CFG_CLOCK_PERIOD, {18'd0, per});
    @(posedge clk);
    idle_pct = idle;
    repeat (n) push(rand_item());
    long_hold = hold;
  endtask

  // driver: predict on acceptance, then offer the next item
  always @(negedge clk) begin
    if (req_fire) begin
      taken = pending_items.pop_front();
      expected_rsp.push_back(console_next(taken));
    end
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_fire) begin
      req_valid <= 1'b1;
    end else if (src_gap != 0) begin
      src_gap--;
      req_valid <= 1'b0;
    end else if (pending_items.size() != 0 && idle_pct != 0 &&
                 $urandom_range(0, 99) < idle_pct) begin
      src_gap = $urandom_range(0, 16);
      req_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      req_valid <= 1'b1;
      req <= pending_items[0];
    end else begin
      req_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (long_hold != 0) begin
      long_hold--;
      rsp_stall <= 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap--;
      rsp_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      sink_gap = $urandom_range(0, 16);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected item", rsp.read_data, 16'h0000);
      end else begin
        want = expected_rsp.pop_front();
        in_flight--;
        if (rsp.read_data !== want.read_data)
          report("read_data", rsp.read_data, want.read_data);
        if (rsp.bus_error !== want.bus_error)
          report("bus_error", rsp.bus_error, want.bus_error);
        if (rsp.char_valid !== want.char_valid)
          report("char_valid", rsp.char_valid, want.char_valid);
        if (rsp.char_code !== want.char_code)
          report("char_code", rsp.char_code, want.char_code);
        if (rsp.irq_source !== want.irq_source)
          report("irq_source", rsp.irq_source, want.irq_source);
        if (rsp.end_key_seen !== want.end_key_seen)
          report("end_key_seen", rsp.end_key_seen, want.end_key_seen);
      end
    end
  end

  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);
    idle_pct = 10;
    push(mk_item(FUNC_READ, 1'b0, ADDR_RCSR, 16'h0000, 8'h00));
    push(mk_item(FUNC_READ, 1'b0, ADDR_TBUF, 16'hFFFF, 8'hFF));
    push(mk_item(FUNC_READ, 1'b0, ADDR_LKS, 16'h0000, 8'h00));
    push(mk_item(FUNC_READ, 1'b0, 16'h0000, 16'h0000, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_SWR, 16'hFFFF, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b1, ADDR_SWR, 16'hABCD, 8'h00));
    push(mk_item(FUNC_READ, 1'b0, ADDR_SWR, 16'h0000, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_RBUF, 16'h1234, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, 16'hFFFF, 16'hFFFF, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_PSB, 16'hFFFF, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_LKS, 16'hFFFF, 8'h00));
    push(mk_item(FUNC_READ, 1'b1, ADDR_PSB, 16'h0000, 8'h00));
    push(mk_item(FUNC_KEY, 1'b0, 16'h0000, 16'h0000, KEY_CTRL));
    push(mk_item(FUNC_READ, 1'b0, ADDR_RBUF, 16'h0000, 8'h00));
    push(mk_item(FUNC_KEY, 1'b0, 16'h0000, 16'h0000, KEY_BS));
    push(mk_item(FUNC_READ, 1'b0, ADDR_RCSR, 16'h0000, 8'h00));
    push(mk_item(FUNC_KEY, 1'b0, 16'h0000, 16'h0000, 8'hFF));
    push(mk_item(FUNC_READ, 1'b1, ADDR_RBUF, 16'h0000, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_TBUF, 16'h0000, 8'h00));
    push(mk_item(FUNC_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_TBUF, 16'hFF87, 8'h00));
    push(mk_item(FUNC_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00));
    push(mk_item(FUNC_READ, 1'b0, ADDR_TCSR, 16'h0000, 8'h00));
    push(mk_item(FUNC_KEY, 1'b0, 16'h0000, 16'h0000, KEY_END));

    settle();
    write_reg(CFG_IRQ_DELAY, 32'd2);
    write_reg(CFG_CLOCK_PERIOD, 32'd1);
    @(posedge clk);
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_RCSR, 16'hFFFF, 8'h00));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_TCSR, 16'h0040, 8'h00));
    push(mk_item(FUNC_KEY, 1'b0, 16'h0000, 16'h0000, 8'h41));
    push(mk_item(FUNC_WRITE, 1'b0, ADDR_LKS, 16'h0040, 8'h00));
    repeat (6) push(mk_item(FUNC_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00));
    push(mk_item(FUNC_READ, 1'b0, ADDR_LKS, 16'h0000, 8'h00));

    run_random(6'd63, 14'd16383, 100, 15, 0);
    run_random(6'd2, 14'd1, 100, 0, 150);
    run_random(6'($urandom_range(2, 63)), 14'($urandom_range(1, 50)), 100, 20, 0);
    run_random(6'd1, 14'd3, 60, 10, 0);
    run_random(6'd0, 14'd7, 60, 10, 0);

    run_random(IRQ_DELAY_RESET, CLOCK_PERIOD_RESET, 80, 0, 0);
    settle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: console_serial_and_clock_regs.f
hw/rtl/cscr_pkg.sv
hw/rtl/console_serial_and_clock_regs.sv
tb/tb.sv
